@@ hdl/rwat_pkg.sv @@
// Package for the receive window tracker: payload structs, status codes,
// register indexes, controller state and command/status types. No dependencies.
package rwat_pkg;

    // Default sizes handed to the top-level parameters.
    localparam int WINDOW_DEF       = 64;
    localparam int NUM_CHANNELS_DEF = 4;
    localparam int SEQ_BITS_DEF     = 16;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_RELIABLE_MASK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORDERED_CHAN  = 2'd1;

    localparam logic [3:0] RELIABLE_MASK_RST = 4'h1;
    localparam logic [1:0] ORDERED_CHAN_RST  = 2'd2;

    typedef enum logic [1:0] {
        STAT_OUTSIDE  = 2'd0,
        STAT_DUPLICATE = 2'd1,
        STAT_ACCEPTED = 2'd2,
        STAT_HELD     = 2'd3
    } rwat_status_t;

    typedef struct packed {
        logic [1:0]  chan;
        logic [15:0] seq_num;
    } rwat_in_t;

    typedef struct packed {
        rwat_status_t status;
        logic [15:0]  expected_after;
        logic         replay_pending;
    } rwat_out_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_CLASSIFY,
        S_ADVANCE,
        S_FINISH
    } rwat_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic load;
        logic classify;
        logic advance;
        logic finish;
    } rwat_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic go_advance;
        logic adv_more;
        logic out_free;
    } rwat_sts_t;

endpackage

@@ hdl/rwat_ctrl.sv @@
// Controller state machine for the receive window tracker.
// Depends on rwat_pkg for the state, command and status types.
module rwat_ctrl
    import rwat_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output rwat_cmd_t cmd_o,
    input  rwat_sts_t sts_i
);

    rwat_state_t state_reg;
    rwat_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD: begin
                state_next = S_CLASSIFY;
            end
            S_CLASSIFY: begin
                state_next = sts_i.go_advance ? S_ADVANCE : S_FINISH;
            end
            S_ADVANCE: begin
                if (!sts_i.adv_more) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (sts_i.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready        = 1'b0;
        cmd_o          = '0;
        case (state_reg)
            S_IDLE: begin
                s_ready       = 1'b1;
                cmd_o.capture = s_valid;
            end
            S_LOAD: begin
                cmd_o.load = 1'b1;
            end
            S_CLASSIFY: begin
                cmd_o.classify = 1'b1;
            end
            S_ADVANCE: begin
                cmd_o.advance = 1'b1;
            end
            S_FINISH: begin
                cmd_o.finish = sts_i.out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

@@ hdl/rwat_datapath.sv @@
// Datapath of the receive window tracker: per-channel window state, working
// registers, configuration registers and the result register. Uses rwat_pkg.
module rwat_datapath
    import rwat_pkg::*;
#(
    parameter int WINDOW       = WINDOW_DEF,
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
    parameter int SEQ_BITS     = SEQ_BITS_DEF
)(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  rwat_in_t              s_data,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  rwat_cmd_t             cmd_i,
    output rwat_sts_t             sts_o,
    output logic                  m_valid,
    input  logic                  m_ready,
    output rwat_out_t             m_data
);

    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [SLOT_W:0]   WIN_S     = (SLOT_W + 1)'(WINDOW);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);

    // Per-channel state. The slot register tracks next_expected modulo WINDOW.
    logic [WINDOW-1:0]   bits_reg [NUM_CHANNELS];
    logic [SEQ_BITS-1:0] nx_reg   [NUM_CHANNELS];
    logic [SLOT_W-1:0]   slot_reg [NUM_CHANNELS];

    rwat_in_t            in_reg, in_next;
    logic                chan_ok_reg, chan_ok_next;
    logic [WINDOW-1:0]   wk_bits_reg, wk_bits_next;
    logic [SEQ_BITS-1:0] wk_nx_reg, wk_nx_next;
    logic [SLOT_W-1:0]   wk_slot_reg, wk_slot_next;
    rwat_status_t        res_status_reg, res_status_next;
    rwat_out_t           out_reg, out_next;
    logic                out_valid_reg, out_valid_next;
    logic [3:0]          mask_reg, mask_next;
    logic [1:0]          oc_reg, oc_next;

    logic [CH_W-1:0]     chan_idx, oc_idx, rd_idx;
    logic                chan_ok_c, oc_ok;
    logic [WINDOW-1:0]   rd_bits, rp_bits;
    logic [SEQ_BITS-1:0] rd_nx;
    logic [SLOT_W-1:0]   rd_slot, rp_slot;
    logic [SEQ_BITS-1:0] seq_ext, seq_dist, nx_inc;
    logic                in_win, wrap, hit, rel, adv_more, replay;
    logic [SLOT_W:0]     slot_sum, slot_fold;
    logic [SLOT_W-1:0]   seq_slot, slot_inc;
    logic [WINDOW-1:0]   seq_bit, cur_bit;

    assign chan_idx  = CH_W'(in_reg.chan);
    assign oc_idx    = CH_W'(oc_reg);
    assign chan_ok_c = 32'(in_reg.chan) < NUM_CHANNELS;
    assign oc_ok     = 32'(oc_reg) < NUM_CHANNELS;

    // One read port: the input channel while loading, the ordered channel otherwise.
    assign rd_idx  = cmd_i.load ? chan_idx : oc_idx;
    assign rd_bits = bits_reg[rd_idx];
    assign rd_nx   = nx_reg[rd_idx];
    assign rd_slot = slot_reg[rd_idx];

    // Window test and slot of the incoming sequence. When the sequence lies past
    // the wrap of the sequence space it is below WINDOW and is its own slot.
    assign seq_ext   = SEQ_BITS'(in_reg.seq_num);
    assign seq_dist  = seq_ext - wk_nx_reg;
    assign in_win    = seq_dist < SEQ_BITS'(WINDOW);
    assign wrap      = seq_ext < wk_nx_reg;
    assign slot_sum  = {1'b0, wk_slot_reg} + {1'b0, seq_dist[SLOT_W-1:0]};
    assign slot_fold = (slot_sum >= WIN_S) ? (slot_sum - WIN_S) : slot_sum;
    assign seq_slot  = wrap ? seq_ext[SLOT_W-1:0] : slot_fold[SLOT_W-1:0];
    assign seq_bit   = WINDOW'(1) << seq_slot;
    assign hit       = |(wk_bits_reg & seq_bit);
    assign rel       = mask_reg[in_reg.chan];

    assign cur_bit   = WINDOW'(1) << wk_slot_reg;
    assign adv_more  = |(wk_bits_reg & cur_bit);
    assign nx_inc    = wk_nx_reg + SEQ_BITS'(1);
    assign slot_inc  = ((&wk_nx_reg) || (wk_slot_reg == LAST_SLOT)) ? '0
                     : wk_slot_reg + SLOT_W'(1);

    // The ordered channel may be the one being written back this cycle.
    always_comb begin
        if (chan_ok_reg && (oc_idx == chan_idx)) begin
            rp_bits = wk_bits_reg;
            rp_slot = wk_slot_reg;
        end else begin
            rp_bits = rd_bits;
            rp_slot = rd_slot;
        end
    end
    assign replay = oc_ok && (|(rp_bits & (WINDOW'(1) << rp_slot)));

    assign sts_o.go_advance = chan_ok_reg && in_win && !hit && rel;
    assign sts_o.adv_more   = adv_more;
    assign sts_o.out_free   = !out_valid_reg || m_ready;

    always_comb begin
        in_next         = in_reg;
        chan_ok_next    = chan_ok_reg;
        wk_bits_next    = wk_bits_reg;
        wk_nx_next      = wk_nx_reg;
        wk_slot_next    = wk_slot_reg;
        res_status_next = res_status_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        mask_next       = mask_reg;
        oc_next         = oc_reg;

        if (cmd_i.capture) begin
            in_next = s_data;
        end

        if (cmd_i.load) begin
            chan_ok_next = chan_ok_c;
            wk_bits_next = rd_bits;
            wk_nx_next   = rd_nx;
            wk_slot_next = rd_slot;
        end

        if (cmd_i.classify) begin
            if (!chan_ok_reg || !in_win) begin
                res_status_next = STAT_OUTSIDE;
            end else if (hit) begin
                res_status_next = STAT_DUPLICATE;
            end else if (rel) begin
                wk_bits_next    = wk_bits_reg | seq_bit;
                res_status_next = STAT_ACCEPTED;
            end else if (seq_dist == '0) begin
                wk_bits_next    = wk_bits_reg & ~seq_bit;
                wk_nx_next      = nx_inc;
                wk_slot_next    = slot_inc;
                res_status_next = STAT_ACCEPTED;
            end else begin
                wk_bits_next    = wk_bits_reg | seq_bit;
                res_status_next = STAT_HELD;
            end
        end

        // One step of the window advance over consecutive set bits.
        if (cmd_i.advance && adv_more) begin
            wk_bits_next = wk_bits_reg & ~cur_bit;
            wk_nx_next   = nx_inc;
            wk_slot_next = slot_inc;
        end

        if (cmd_i.finish) begin
            out_next.status         = res_status_reg;
            out_next.expected_after = chan_ok_reg ? 16'(wk_nx_reg) : '0;
            out_next.replay_pending = replay;
            out_valid_next          = 1'b1;
        end

        if (cfg_valid) begin
            case (cfg_index)
                CFG_RELIABLE_MASK: begin
                    mask_next = cfg_data;
                end
                CFG_ORDERED_CHAN: begin
                    oc_next = cfg_data[1:0];
                end
                default: begin
                    mask_next = mask_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            chan_ok_reg   <= 1'b0;
            mask_reg      <= RELIABLE_MASK_RST;
            oc_reg        <= ORDERED_CHAN_RST;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                bits_reg[i] <= '0;
                nx_reg[i]   <= '0;
                slot_reg[i] <= '0;
            end
        end else begin
            out_valid_reg <= out_valid_next;
            chan_ok_reg   <= chan_ok_next;
            mask_reg      <= mask_next;
            oc_reg        <= oc_next;
            if (cmd_i.finish && chan_ok_reg) begin
                bits_reg[chan_idx] <= wk_bits_reg;
                nx_reg[chan_idx]   <= wk_nx_reg;
                slot_reg[chan_idx] <= wk_slot_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        in_reg         <= in_next;
        wk_bits_reg    <= wk_bits_next;
        wk_nx_reg      <= wk_nx_next;
        wk_slot_reg    <= wk_slot_next;
        res_status_reg <= res_status_next;
        out_reg        <= out_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    a_finish_only_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_i.finish |-> (!out_valid_reg || m_ready))
        else $error("result loaded while the output register still holds a beat");

    a_finish_gives_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_i.finish |=> m_valid)
        else $error("finished item did not produce a result beat");

    a_advance_steps_one: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd_i.advance && adv_more) |=> (wk_nx_reg == $past(wk_nx_reg) + SEQ_BITS'(1)))
        else $error("window advance did not move next expected by one");

    a_slot_in_window: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd_i.advance && chan_ok_reg) |-> (wk_slot_reg <= LAST_SLOT))
        else $error("working slot outside the window");

    a_bad_chan_outside: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd_i.classify && !chan_ok_reg) |=> (res_status_reg == STAT_OUTSIDE))
        else $error("out-of-range channel not reported as outside the window");

endmodule

@@ hdl/receive_window_ack_tracker.sv @@
// Top level of the receive window tracker: controller and datapath.
// Depends on rwat_pkg, rwat_ctrl and rwat_datapath.
//
// Usage: each input beat on s_* carries a channel number and a sequence number.
// The block answers every input beat with exactly one result beat on m_*, in
// order: the status (outside window, duplicate, accepted, held for replay), the
// channel's next expected sequence after the update, and a flag telling whether
// the ordered channel holds the entry at its own next expected sequence.
// Configuration beats on cfg_* are always taken and set the reliable-channel
// mask and the ordered channel; they are meant to arrive while no item is open.
// Sequence: an item that is rejected or lands on a non-reliable channel passes
// through the load, classify and finish states after acceptance; when a
// reliable channel takes it into its window, an advance state comes between
// classify and finish, where the window advances over k entries; it walks one
// bitmap entry per cycle through a single sequencer loop, so k is 0 to WINDOW.
// The finish state loads the result into the output register once it is free.
// When the receiver stalls, the result waits in the output register; the block
// keeps accepting and working one further item and then holds it until the
// output register frees up. Reset (aresetn low at a clock edge) clears all
// windows to zero, the mask to channel 0 only and the ordered channel to 2.
module receive_window_ack_tracker
    import rwat_pkg::*;
#(
    parameter int WINDOW       = WINDOW_DEF,
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
    parameter int SEQ_BITS     = SEQ_BITS_DEF
)(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  rwat_in_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output rwat_out_t             m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    rwat_cmd_t cmd;
    rwat_sts_t sts;

    // Configuration registers are plain flops, so a write never has to wait.
    assign cfg_ready = 1'b1;

    rwat_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd_o   (cmd),
        .sts_i   (sts)
    );

    rwat_datapath #(
        .WINDOW       (WINDOW),
        .NUM_CHANNELS (NUM_CHANNELS),
        .SEQ_BITS     (SEQ_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_i     (cmd),
        .sts_o     (sts),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for receive_window_ack_tracker: per-channel window
// predictor, queue-fed beat driver, result monitor and watchdog.
// Depends on rwat_pkg and the receive_window_ack_tracker RTL.
`timescale 1ns / 100ps

module testbench;
    import rwat_pkg::*;

    localparam int CLK_HALF      = 2;
    localparam int RESET_CYCLES  = 12;
    localparam int WIN           = WINDOW_DEF;
    localparam int NCH           = NUM_CHANNELS_DEF;
    localparam int SLOT_W        = $clog2(WINDOW_DEF);
    localparam int MAX_WAIT      = 10;
    localparam int RANDOM_ITEMS  = 1350;
    localparam int PHASE_ITEMS   = 150;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 100;
    localparam int STALL_LIMIT   = 2000;
    localparam int MAX_REPORTS   = 40;

    // Register indexes the block does not define; writes to them must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    rwat_in_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    rwat_out_t             m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Predicted state of the tracker.
    logic [15:0]    win_next [NCH];
    logic [WIN-1:0] win_bits [NCH];
    logic [3:0]     rel_mask;
    logic [1:0]     ord_chan;

    rwat_in_t  msg_queue[$];       // messages waiting to be driven
    rwat_out_t predicted_acks[$];  // acknowledgements still to come back

    bit no_idle   = 1'b0;
    int err_count = 0;
    int msg_count = 0;
    int idle_run  = 0;

    always #CLK_HALF aclk = ~aclk;

    receive_window_ack_tracker DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Applies one message to the predicted window state and returns the
    // acknowledgement the block should send for it.
    function automatic rwat_out_t track_window(rwat_in_t msg);
        rwat_out_t        ack;
        logic [1:0]       c;
        logic [15:0]      nx;
        logic [15:0]      offset;
        logic [SLOT_W-1:0] slot;
        int               n;
        c      = msg.chan;
        nx     = win_next[c];
        offset = msg.seq_num - nx;
        slot   = msg.seq_num[SLOT_W-1:0];
        if (offset >= WIN) begin
            ack.status = STAT_OUTSIDE;
        end else if (win_bits[c][slot]) begin
            ack.status = STAT_DUPLICATE;
        end else if (rel_mask[c]) begin
            // Mark the entry, then slide over every consecutive marked entry.
            win_bits[c][slot] = 1'b1;
            for (n = 0; n < WIN && win_bits[c][nx[SLOT_W-1:0]]; n++) begin
                win_bits[c][nx[SLOT_W-1:0]] = 1'b0;
                nx = nx + 16'd1;
            end
            win_next[c] = nx;
            ack.status  = STAT_ACCEPTED;
        end else if (offset == 0) begin
            win_bits[c][slot] = 1'b0;
            win_next[c]       = nx + 16'd1;
            ack.status        = STAT_ACCEPTED;
        end else begin
            win_bits[c][slot] = 1'b1;
            ack.status        = STAT_HELD;
        end
        ack.expected_after = win_next[c];
        ack.replay_pending = win_bits[ord_chan][win_next[ord_chan][SLOT_W-1:0]];
        return ack;
    endfunction

    task automatic report_mismatch(input string what, input int got_v, input int want_v);
        err_count++;
        // Keep the log readable when something is badly broken.
        if (err_count <= MAX_REPORTS)
            $display("%0t ns: %s: got %0d, expected %0d", $time, what, got_v, want_v);
    endtask

    // Message driver: one beat at a time from msg_queue, with a random gap
    // before each following beat.
    always @(posedge aclk) begin : msg_driver
        int gap_left;
        if (!aresetn) begin
            s_valid  <= 1'b0;
            gap_left = 0;
        end else begin
            if (s_valid && s_ready)
                predicted_acks.push_back(track_window(s_data));
            if (!s_valid || s_ready) begin
                if (gap_left != 0) begin
                    s_valid  <= 1'b0;
                    gap_left = gap_left - 1;
                end else if (msg_queue.size() != 0) begin
                    s_valid  <= 1'b1;
                    s_data   <= msg_queue.pop_front();
                    gap_left = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Acknowledgement monitor: checks each beat against the oldest prediction,
    // then stalls for a random number of cycles.
    always @(posedge aclk) begin : ack_monitor
        rwat_out_t want;
        int        stall_left;
        int        n;
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left = 0;
        end else if (m_valid && m_ready) begin
            if (predicted_acks.size() == 0) begin
                report_mismatch("result beat with nothing expected", m_data.expected_after, 0);
            end else begin
                want = predicted_acks.pop_front();
                if (m_data.status !== want.status)
                    report_mismatch("status", m_data.status, want.status);
                if (m_data.expected_after !== want.expected_after)
                    report_mismatch("expected_after", m_data.expected_after,
                                    want.expected_after);
                if (m_data.replay_pending !== want.replay_pending)
                    report_mismatch("replay_pending", m_data.replay_pending,
                                    want.replay_pending);
            end
            n          = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
            stall_left = n;
            m_ready    <= (n == 0);
        end else if (stall_left != 0) begin
            stall_left = stall_left - 1;
            m_ready    <= (stall_left == 0);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Watchdog: ends the run when no beat moves on any channel for too long.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                idle_run <= 0;
            else if (idle_run >= STALL_LIMIT) begin
                $display("Watchdog: no beat for %0d cycles", STALL_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end else
                idle_run <= idle_run + 1;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == CFG_RELIABLE_MASK)
            rel_mask = val[3:0];
        else if (idx == CFG_ORDERED_CHAN)
            ord_chan = val[1:0];
    endtask

    task automatic send_msg(input logic [1:0] c, input logic [15:0] seq);
        rwat_in_t msg;
        msg.chan    = c;
        msg.seq_num = seq;
        msg_queue.push_back(msg);
        msg_count++;
    endtask

    // Waits until every queued message is on its way, so the predicted state is current.
    task automatic sync_feed();
        do @(negedge aclk);
        while (msg_queue.size() != 0 || s_valid);
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (msg_queue.size() != 0 || s_valid || predicted_acks.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // A sequence number near the window: in order, inside, at its edges, just
    // outside on either side, or anywhere at all.
    function automatic logic [15:0] stray_seq(input logic [15:0] nx);
        case ($urandom_range(0, 9))
            0:          return nx;
            1, 2, 3, 4: return nx + 16'($urandom_range(0, 15));
            5:          return nx + 16'($urandom_range(16, 63));
            6:          return nx + 16'($urandom_range(63, 64));
            7:          return nx + 16'($urandom_range(65, 70));
            8:          return nx - 16'($urandom_range(1, 5));
            default:    return 16'($urandom);
        endcase
    endfunction

    // A run of consecutive sequence numbers from the channel's window start,
    // sent in reverse or shuffled order, with the odd stray beat mixed in.
    task automatic queue_burst(input logic [1:0] c, input int len, input bit reversed);
        logic [15:0] base;
        logic [15:0] seqs [$];
        logic [15:0] t;
        int          j;
        int          k;
        sync_feed();
        base = win_next[c];
        for (j = 0; j < len; j++)
            seqs.push_back(reversed ? base + 16'(len - 1 - j) : base + 16'(j));
        if (!reversed) begin
            for (j = len - 1; j > 0; j--) begin
                k       = $urandom_range(0, j);
                t       = seqs[j];
                seqs[j] = seqs[k];
                seqs[k] = t;
            end
        end
        for (j = 0; j < len; j++) begin
            send_msg(c, seqs[j]);
            if ($urandom_range(0, 11) == 0)
                send_msg(c, ($urandom_range(0, 1) == 0) ? seqs[j] : stray_seq(base));
        end
    endtask

    initial begin : stimulus
        int         ph;
        int         phase_start;
        int         random_start;
        int         len;
        int         i;
        logic [1:0] c;

        for (i = 0; i < NCH; i++) begin
            win_next[i] = '0;
            win_bits[i] = '0;
        end
        rel_mask = RELIABLE_MASK_RST;
        ord_chan = ORDERED_CHAN_RST;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part, reset configuration: channel 0 reliable, channel 2 ordered.
        send_msg(2'd0, 16'd0);      // in order
        send_msg(2'd0, 16'd2);      // ahead of the window start, marked
        send_msg(2'd0, 16'd1);      // fills the gap, the window slides over both
        send_msg(2'd0, 16'd66);     // last slot of the window
        send_msg(2'd0, 16'd67);     // first slot past the window
        send_msg(2'd0, 16'd65535);  // just behind the window, across the wrap
        send_msg(2'd0, 16'd66);     // duplicate
        send_msg(2'd2, 16'd0);      // unreliable, in order
        send_msg(2'd2, 16'd5);      // held
        send_msg(2'd2, 16'd1);
        send_msg(2'd2, 16'd3);      // held
        send_msg(2'd2, 16'd2);      // now the ordered channel has a replay pending
        send_msg(2'd2, 16'd3);      // held entry again: duplicate
        send_msg(2'd1, 16'd65535);  // behind a fresh window
        send_msg(2'd1, 16'd63);     // far edge, held
        send_msg(2'd1, 16'd0);
        send_msg(2'd3, 16'd0);
        wait_drained();

        // All channels reliable: channel 2 slides over its held entries.
        write_reg(CFG_RELIABLE_MASK, 4'hF);
        write_reg(CFG_ORDERED_CHAN, 4'hF);
        write_reg(CFG_SPARE_2, 4'h0);
        write_reg(CFG_SPARE_3, 4'hA);
        send_msg(2'd2, 16'd4);
        send_msg(2'd1, 16'd1);
        send_msg(2'd3, 16'hFFFF);
        wait_drained();

        // Random part in phases, each under its own register setting. The
        // drain between phases also holds the sender until all results are back.
        random_start = msg_count;
        for (ph = 0; msg_count - random_start < RANDOM_ITEMS; ph++) begin
            wait_drained();
            case (ph)
                0: begin
                    write_reg(CFG_RELIABLE_MASK, 4'h0);
                    write_reg(CFG_ORDERED_CHAN, 4'h0);
                end
                1: begin
                    write_reg(CFG_RELIABLE_MASK, 4'hF);
                    write_reg(CFG_ORDERED_CHAN, 4'h3);
                end
                default: begin
                    write_reg(CFG_RELIABLE_MASK, CFG_DATA_W'($urandom));
                    write_reg(CFG_ORDERED_CHAN, CFG_DATA_W'($urandom));
                end
            endcase
            no_idle     = (ph % 3 == 2);
            phase_start = msg_count;
            while (msg_count - phase_start < PHASE_ITEMS) begin
                c = 2'($urandom_range(0, NCH - 1));
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: begin
                        len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, WIN)
                                                          : $urandom_range(1, 16);
                        queue_burst(c, len, 1'b0);
                    end
                    4, 5:    queue_burst(c, $urandom_range(1, WIN), 1'b1);
                    default: send_msg(c, stray_seq(win_next[c]));
                endcase
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (predicted_acks.size() != 0)
            report_mismatch("results never delivered", 0, predicted_acks.size());
        if (err_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
